// ===== hw/rtl/aaf_pkg.sv =====
// Shared constants and arctangent table for the aim angle CORDIC pipeline.
package aaf_pkg;

    localparam int GUARD_BITS = 16;
    localparam int AW         = 36;
    localparam int YAW_W      = 16;
    localparam int PITCH_W    = 15;
    localparam int OUT_TDATA_W = 32;
    localparam int K_W        = 31;
    localparam int K_SHIFT    = 30 - GUARD_BITS;

    localparam logic [K_W-1:0] K_Q30 = 31'd1768195363;

    localparam logic signed [63:0] PI_Q32      = 64'sd13493037705;
    localparam logic signed [63:0] HALF_PI_Q32 = 64'sd6746518852;

    localparam logic [31:0] ATAN_Q32 [0:31] = '{
        32'hC90FDAA2, 32'h76B19C16, 32'h3EB6EBF2, 32'h1FD5BA9B,
        32'h0FFAADDC, 32'h07FF556F, 32'h03FFEAAB, 32'h01FFFD55,
        32'h00FFFFAB, 32'h007FFFF5, 32'h003FFFFF, 32'h00200000,
        32'h00100000, 32'h00080000, 32'h00040000, 32'h00020000,
        32'h00010000, 32'h00008000, 32'h00004000, 32'h00002000,
        32'h00001000, 32'h00000800, 32'h00000400, 32'h00000200,
        32'h00000100, 32'h00000080, 32'h00000040, 32'h00000020,
        32'h00000010, 32'h00000008, 32'h00000004, 32'h00000002
    };

endpackage

// ===== hw/rtl/aaf_prerot.sv =====
// Quadrant fold ahead of a vectoring CORDIC chain, with zero-vector detect.
module aaf_prerot
    import aaf_pkg::*;
#(
    parameter int XW = 36,
    parameter int PW = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] in_a,
    input  logic signed [XW-1:0] in_b,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic signed [XW-1:0] out_a,
    output logic signed [XW-1:0] out_b,
    output logic signed [AW-1:0] out_ang,
    output logic                 out_zero,
    output logic [PW-1:0]        out_pay
);

    localparam logic signed [AW-1:0] HALF_PI = AW'(HALF_PI_Q32);

    logic                 valid_reg;
    logic signed [XW-1:0] a_reg, a_next;
    logic signed [XW-1:0] b_reg, b_next;
    logic signed [AW-1:0] ang_reg, ang_next;
    logic                 zero_reg, zero_next;
    logic [PW-1:0]        pay_reg;

    always_comb
    begin
        a_next    = in_a;
        b_next    = in_b;
        ang_next  = '0;
        zero_next = (in_a == '0) && (in_b == '0);
        if (in_a[XW-1])
        begin
            if (!in_b[XW-1])
            begin
                a_next   = in_b;
                b_next   = -in_a;
                ang_next = HALF_PI;
            end
            else
            begin
                a_next   = -in_b;
                b_next   = in_a;
                ang_next = -HALF_PI;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            ang_reg  <= ang_next;
            zero_reg <= zero_next;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_ang   = ang_reg;
    assign out_zero  = zero_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== hw/rtl/aaf_cell.sv =====
// One vectoring CORDIC micro-rotation stage with its pipeline register.
module aaf_cell
    import aaf_pkg::*;
#(
    parameter int XW    = 36,
    parameter int PW    = 1,
    parameter int STAGE = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] in_a,
    input  logic signed [XW-1:0] in_b,
    input  logic signed [AW-1:0] in_ang,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic signed [XW-1:0] out_a,
    output logic signed [XW-1:0] out_b,
    output logic signed [AW-1:0] out_ang,
    output logic [PW-1:0]        out_pay
);

    localparam logic signed [AW-1:0] ATAN_STEP = {{(AW-32){1'b0}}, ATAN_Q32[STAGE]};

    logic                 valid_reg;
    logic signed [XW-1:0] a_reg, a_next;
    logic signed [XW-1:0] b_reg, b_next;
    logic signed [AW-1:0] ang_reg, ang_next;
    logic [PW-1:0]        pay_reg;
    logic signed [XW-1:0] da;
    logic signed [XW-1:0] db;

    assign da = in_b >>> STAGE;
    assign db = in_a >>> STAGE;

    always_comb
    begin
        if (!in_b[XW-1])
        begin
            a_next   = in_a + da;
            b_next   = in_b - db;
            ang_next = in_ang + ATAN_STEP;
        end
        else
        begin
            a_next   = in_a - da;
            b_next   = in_b + db;
            ang_next = in_ang - ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            ang_reg <= ang_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_ang   = ang_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== hw/rtl/aaf_chain.sv =====
// Row of CORDIC cells, one per iteration, each handing its vector to the next.
module aaf_chain
    import aaf_pkg::*;
#(
    parameter int XW     = 36,
    parameter int PW     = 1,
    parameter int STAGES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] in_a,
    input  logic signed [XW-1:0] in_b,
    input  logic signed [AW-1:0] in_ang,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic signed [XW-1:0] out_a,
    output logic signed [AW-1:0] out_ang,
    output logic [PW-1:0]        out_pay
);

    logic                 v_s   [0:STAGES];
    logic signed [XW-1:0] a_s   [0:STAGES];
    logic signed [XW-1:0] b_s   [0:STAGES];
    logic signed [AW-1:0] ang_s [0:STAGES];
    logic [PW-1:0]        pay_s [0:STAGES];

    assign v_s[0]   = in_valid;
    assign a_s[0]   = in_a;
    assign b_s[0]   = in_b;
    assign ang_s[0] = in_ang;
    assign pay_s[0] = in_pay;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        aaf_cell #(
            .XW    (XW),
            .PW    (PW),
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_s[i]),
            .in_a      (a_s[i]),
            .in_b      (b_s[i]),
            .in_ang    (ang_s[i]),
            .in_pay    (pay_s[i]),
            .out_valid (v_s[i+1]),
            .out_a     (a_s[i+1]),
            .out_b     (b_s[i+1]),
            .out_ang   (ang_s[i+1]),
            .out_pay   (pay_s[i+1])
        );
    end

    assign out_valid = v_s[STAGES];
    assign out_a     = a_s[STAGES];
    assign out_ang   = ang_s[STAGES];
    assign out_pay   = pay_s[STAGES];

endmodule

// ===== hw/rtl/aim_angles_from_point.sv =====
// Top level: target point to yaw and pitch angles through two CORDIC chains.
//
// Slave stream takes one request per point: x, y, z packed in s_tdata.
// Master stream returns yaw = atan2(z, x) and pitch = atan2(y, sqrt(x^2+z^2)),
// both signed radians with ANGLE_FRAC_BITS fraction bits.
// A new request is taken every cycle while the output is free or being read.
// Pipeline: one fold stage before each chain, one cell per iteration in each
// chain, and one rounding / output register.
// The first chain also delivers the magnitude s times the CORDIC gain; y is
// multiplied by the same gain on entry so the gain cancels in the second.
// The whole pipe advances as one; when m_tvalid is high and m_tready low the
// pipe freezes and s_tready drops, nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
// A zero vector gives an angle of exactly zero.
module aim_angles_from_point
    import aaf_pkg::*;
#(
    parameter int COORD_WIDTH     = 16,
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 13
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // x_coord, y_coord, z_coord
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // yaw_angle, pitch_angle
    output logic [OUT_TDATA_W-1:0]                   m_tdata
);

    localparam int CW     = COORD_WIDTH;
    localparam int XW     = CW + 20;
    localparam int PROD_W = CW + K_W + 1;
    localparam int YK_W   = PROD_W - K_SHIFT;
    localparam int RSH    = 32 - ANGLE_FRAC_BITS;

    localparam logic signed [AW:0] RND_HALF =
        (AW+1)'(64'sd1 <<< (31 - ANGLE_FRAC_BITS));
    localparam logic signed [AW:0] YAW_LIM =
        (AW+1)'((PI_Q32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS))) >>> RSH);
    localparam logic signed [AW:0] PITCH_LIM =
        (AW+1)'((HALF_PI_Q32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS))) >>> RSH);

    logic                     en;
    logic signed [CW-1:0]     x_in, y_in, z_in;
    logic signed [XW-1:0]     xs, zs;
    logic signed [PROD_W-1:0] yprod;
    logic [YK_W-1:0]          yk;

    logic                     p1_valid, p1_zero;
    logic signed [XW-1:0]     p1_a, p1_b;
    logic signed [AW-1:0]     p1_ang;
    logic [YK_W-1:0]          p1_yk;

    logic                     c1_valid;
    logic signed [XW-1:0]     c1_a;
    logic signed [AW-1:0]     c1_ang;
    logic [YK_W:0]            c1_pay;
    logic                     c1_zero;
    logic signed [YK_W-1:0]   c1_yk;
    logic signed [AW-1:0]     yaw_q;

    logic                     p2_valid, p2_zero;
    logic signed [XW-1:0]     p2_a, p2_b;
    logic signed [AW-1:0]     p2_ang;
    logic [AW-1:0]            p2_yaw;

    logic                     c2_valid;
    logic signed [XW-1:0]     c2_a;
    logic signed [AW-1:0]     c2_ang;
    logic [AW:0]              c2_pay;
    logic                     c2_zero;
    logic signed [AW-1:0]     c2_yaw;
    logic signed [AW-1:0]     pitch_q;

    logic signed [AW:0]       yaw_r, pitch_r;
    logic signed [AW:0]       yaw_sat, pitch_sat;

    logic                     out_valid_reg;
    logic [YAW_W-1:0]         yaw_reg;
    logic [PITCH_W-1:0]       pitch_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign x_in = s_tdata[CW-1:0];
    assign y_in = s_tdata[2*CW-1:CW];
    assign z_in = s_tdata[3*CW-1:2*CW];

    assign xs    = {{(XW-CW-GUARD_BITS){x_in[CW-1]}}, x_in, {GUARD_BITS{1'b0}}};
    assign zs    = {{(XW-CW-GUARD_BITS){z_in[CW-1]}}, z_in, {GUARD_BITS{1'b0}}};
    assign yprod = y_in * $signed({1'b0, K_Q30});
    assign yk    = yprod[PROD_W-1:K_SHIFT];

    aaf_prerot #(
        .XW (XW),
        .PW (YK_W)
    ) u_fold_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_a      (xs),
        .in_b      (zs),
        .in_pay    (yk),
        .out_valid (p1_valid),
        .out_a     (p1_a),
        .out_b     (p1_b),
        .out_ang   (p1_ang),
        .out_zero  (p1_zero),
        .out_pay   (p1_yk)
    );

    aaf_chain #(
        .XW     (XW),
        .PW     (YK_W + 1),
        .STAGES (CORDIC_STAGES)
    ) u_chain_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p1_valid),
        .in_a      (p1_a),
        .in_b      (p1_b),
        .in_ang    (p1_ang),
        .in_pay    ({p1_yk, p1_zero}),
        .out_valid (c1_valid),
        .out_a     (c1_a),
        .out_ang   (c1_ang),
        .out_pay   (c1_pay)
    );

    assign c1_zero = c1_pay[0];
    assign c1_yk   = c1_pay[YK_W:1];
    assign yaw_q   = c1_zero ? '0 : c1_ang;

    aaf_prerot #(
        .XW (XW),
        .PW (AW)
    ) u_fold_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1_valid),
        .in_a      (c1_a),
        .in_b      ({{(XW-YK_W){c1_yk[YK_W-1]}}, c1_yk}),
        .in_pay    (yaw_q),
        .out_valid (p2_valid),
        .out_a     (p2_a),
        .out_b     (p2_b),
        .out_ang   (p2_ang),
        .out_zero  (p2_zero),
        .out_pay   (p2_yaw)
    );

    aaf_chain #(
        .XW     (XW),
        .PW     (AW + 1),
        .STAGES (CORDIC_STAGES)
    ) u_chain_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid),
        .in_a      (p2_a),
        .in_b      (p2_b),
        .in_ang    (p2_ang),
        .in_pay    ({p2_yaw, p2_zero}),
        .out_valid (c2_valid),
        .out_a     (c2_a),
        .out_ang   (c2_ang),
        .out_pay   (c2_pay)
    );

    assign c2_zero = c2_pay[0];
    assign c2_yaw  = c2_pay[AW:1];
    assign pitch_q = c2_zero ? '0 : c2_ang;

    // round half up, then clamp to +-pi and +-pi/2
    assign yaw_r   = ($signed({c2_yaw[AW-1], c2_yaw}) + RND_HALF) >>> RSH;
    assign pitch_r = ($signed({pitch_q[AW-1], pitch_q}) + RND_HALF) >>> RSH;

    always_comb
    begin
        yaw_sat = yaw_r;
        if (yaw_r > YAW_LIM)
        begin
            yaw_sat = YAW_LIM;
        end
        else if (yaw_r < -YAW_LIM)
        begin
            yaw_sat = -YAW_LIM;
        end
        pitch_sat = pitch_r;
        if (pitch_r > PITCH_LIM)
        begin
            pitch_sat = PITCH_LIM;
        end
        else if (pitch_r < -PITCH_LIM)
        begin
            pitch_sat = -PITCH_LIM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_reg   <= yaw_sat[YAW_W-1:0];
            pitch_reg <= pitch_sat[PITCH_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, pitch_reg, yaw_reg};

`ifndef SYNTH
    a_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (c1_valid && c1_zero) |-> (c1_a == '0))
        else $error("zero vector left nonzero magnitude");

    a_mag_sign: assert property (@(posedge clk) disable iff (!rst_n)
        c1_valid |-> !c1_a[XW-1])
        else $error("magnitude from yaw chain is negative");

    a_zero_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        (c2_valid && c2_zero && en) |=> (m_tdata[YAW_W+PITCH_W-1:YAW_W] == '0))
        else $error("zero vector gave nonzero pitch");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(c2_valid) && $stable(p1_valid))
        else $error("pipe moved while output stalled");
`endif

endmodule

// ===== sim/aim_angles_check.sv =====
// Stream monitor and angle predictor for the aim angle pipeline.
module aim_angles_check
    import aaf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // x_coord, y_coord, z_coord
    input  logic [47:0]            s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // yaw_angle, pitch_angle
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_STAGES = 16;
    localparam int FRAC_BITS  = 13;
    localparam int GUARD      = 16;
    localparam longint GAIN_Q30     = 64'd1768195363;
    localparam longint PI_RAD_Q32   = 64'd13493037705;
    localparam longint HALF_PI_Q32R = 64'd6746518852;

    localparam longint ARCTAN_Q32 [NUM_STAGES] = '{
        64'hC90FDAA2, 64'h76B19C16, 64'h3EB6EBF2, 64'h1FD5BA9B,
        64'h0FFAADDC, 64'h07FF556F, 64'h03FFEAAB, 64'h01FFFD55,
        64'h00FFFFAB, 64'h007FFFF5, 64'h003FFFFF, 64'h00200000,
        64'h00100000, 64'h00080000, 64'h00040000, 64'h00020000
    };

    typedef struct packed {
        logic [15:0] yaw;
        logic [14:0] pitch;
    } aim_angles_t;

    aim_angles_t angles_due [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // vectoring rotation: returns angle of (a, b) in Q32 radians, gain-scaled length in mag
    function automatic longint vector_angle(input longint a_in, input longint b_in,
                                            output longint mag);
        longint a;
        longint b;
        longint t;
        longint da;
        longint db;
        longint ang;
        int i;
        a   = a_in;
        b   = b_in;
        ang = 0;
        mag = 0;
        if (a == 0 && b == 0)
            return 0;
        if (a < 0)
        begin
            if (b >= 0)
            begin
                t = a; a = b; b = -t; ang = HALF_PI_Q32R;
            end
            else
            begin
                t = a; a = -b; b = t; ang = -HALF_PI_Q32R;
            end
        end
        for (i = 0; i < NUM_STAGES; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0)
            begin
                a = a + da; b = b - db; ang = ang + ARCTAN_Q32[i];
            end
            else
            begin
                a = a - da; b = b + db; ang = ang - ARCTAN_Q32[i];
            end
        end
        mag = a;
        return ang;
    endfunction

    function automatic longint round_clamp(input longint ang_q32, input longint limit_q32);
        longint half;
        longint lim;
        longint r;
        half = longint'(1) << (31 - FRAC_BITS);
        lim  = (limit_q32 + half) >>> (32 - FRAC_BITS);
        r    = (ang_q32 + half) >>> (32 - FRAC_BITS);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic aim_angles_t aim_angles_of(input logic [47:0] point);
        longint x;
        longint y;
        longint z;
        longint mag;
        longint dummy;
        longint yk;
        longint yaw_q32;
        longint pitch_q32;
        longint yaw_r;
        longint pitch_r;
        aim_angles_t res;
        x = longint'($signed(point[15:0]));
        y = longint'($signed(point[31:16]));
        z = longint'($signed(point[47:32]));
        yaw_q32   = vector_angle(x <<< GUARD, z <<< GUARD, mag);
        yk        = (y * GAIN_Q30) >>> (30 - GUARD);
        pitch_q32 = vector_angle(mag, yk, dummy);
        yaw_r     = round_clamp(yaw_q32, PI_RAD_Q32);
        pitch_r   = round_clamp(pitch_q32, HALF_PI_Q32R);
        res.yaw   = yaw_r[15:0];
        res.pitch = pitch_r[14:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        aim_angles_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (angles_due.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = angles_due.pop_front();
                    if (m_tdata[15:0] !== want.yaw)
                        report_mismatch($sformatf("yaw_angle %h, expected %h",
                                                  m_tdata[15:0], want.yaw));
                    if (m_tdata[30:16] !== want.pitch)
                        report_mismatch($sformatf("pitch_angle %h, expected %h",
                                                  m_tdata[30:16], want.pitch));
                end
            end
            if (s_tvalid && s_tready)
                angles_due.push_back(aim_angles_of(s_tdata));
            pending <= angles_due.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the aim angle pipeline testbench: clock, reset, stimulus and verdict.
module testbench
    import aaf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_PER_PHASE = 200;
    localparam int  RX_STALL_CYCLES  = 150;
    localparam int  DRAIN_CYCLES     = 40;
    localparam int  CYCLE_LIMIT      = 200000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [47:0]            s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_req   = 0;
    int stall_seen  = 0;
    int stall_left  = 0;
    int cycle_count = 0;

    aim_angles_from_point dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    aim_angles_check angle_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (stall_req != stall_seen)
        begin
            stall_seen = stall_req;
            stall_left = RX_STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [15:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return 16'($urandom());
        if (sel < 90)
            return 16'($signed($urandom_range(128)) - 64);
        if (sel < 95)
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        return '0;
    endfunction

    task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_point(pick_coord(), pick_coord(), pick_coord());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points: zero vector, axes, quadrant folds, saturation edges
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd1, 16'sd0, 16'sd0);
        send_point(-16'sd1, 16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd0, 16'sd1);
        send_point(16'sd0, 16'sd0, -16'sd1);
        send_point(-16'sd5, 16'sd0, 16'sd0);
        send_point(-16'sd100, 16'sd7, -16'sd3);
        send_point(-16'sd100, 16'sd7, 16'sd3);
        send_point(16'sh7FFF, 16'sd0, 16'sh7FFF);
        send_point(16'sh8000, 16'sh8000, 16'sh8000);
        send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_point(16'sh8000, 16'sd0, 16'sd0);
        send_point(16'sh8000, 16'sd0, -16'sd1);
        send_point(16'sd0, 16'sh7FFF, 16'sd0);
        send_point(16'sd0, 16'sh8000, 16'sd0);
        send_point(16'sd0, 16'sd5, 16'sd0);
        send_point(16'sd3, 16'sh8000, 16'sd4);
        send_point(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_point(16'sd12, -16'sd7, 16'sh8000);
        send_point(16'sd1, 16'sd1, 16'sd1);
        send_point(-16'sd1, -16'sd1, -16'sd1);
        send_point(16'sh7FFF, -16'sd1, 16'sh8000);
        wait_drained();

        tx_idle_pct = 33;
        rx_idle_pct = 45;
        send_random(RANDOM_PER_PHASE);

        tx_idle_pct = 45;
        rx_idle_pct = 33;
        send_random(RANDOM_PER_PHASE);
        wait_drained();

        // no idling; output held off long enough to back up the whole pipe
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(50);
        stall_req <= stall_req + 1;
        send_random(RANDOM_PER_PHASE - 50);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/aaf_pkg.sv
hw/rtl/aaf_prerot.sv
hw/rtl/aaf_cell.sv
hw/rtl/aaf_chain.sv
hw/rtl/aim_angles_from_point.sv
sim/aim_angles_check.sv
sim/testbench.sv
